// ===== rtl/list_task_scheduler_macros.svh =====
`ifndef LIST_TASK_SCHEDULER_MACROS_SVH
`define LIST_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define LTS_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication on clk_i, off while rst_ni is low.
`define LTS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/lts_pkg.sv =====
package lts_pkg;

  localparam int unsigned MaxProcessors = 8;
  localparam int unsigned MaxTasks      = 256;

  // Processors compared per scan step (one memory row)
  localparam int unsigned ScanLanes = 4;
  localparam int unsigned LaneW     = 2;

  localparam int unsigned OpW      = 2;
  localparam int unsigned TaskIdW  = 8;
  localparam int unsigned ExecW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ProcOutW = 3;
  localparam int unsigned NumProcW = 4;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // Register index, taken from paddr[2]
  localparam logic RegNumProcessors = 1'b0;

  typedef enum logic [OpW-1:0] {
    OpAddDep = 2'd0,
    OpPlace  = 2'd1,
    OpClear  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StDep,
    StScan,
    StPlace,
    StCommit
  } state_e;

  typedef logic [TimeW-1:0] time_t;

  typedef struct packed {
    logic  valid;
    time_t finish;
  } task_ent_t;

  typedef struct packed {
    logic  clear;
    logic  scan_start;
    logic  commit;
    time_t commit_free;
    time_t commit_delta;
  } proc_ctrl_t;

  typedef struct packed {
    logic                busy;
    logic                scan_done;
    time_t               best_free;
    time_t               load_new;
    logic [ProcOutW-1:0] proc_idx;
  } proc_stat_t;

  function automatic time_t sat_add(time_t a, time_t b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

endpackage

// ===== rtl/list_task_scheduler.sv =====
// list_task_scheduler: places tasks, given in priority order, on the processor
// that frees up first (lowest index on ties).
// Input channel (in_valid_i / in_ready_o): one word per operation. Add
// dependency does one task table read. Place task scans the processor state,
// which sits in a row memory of four processors per row, read one row a cycle;
// then one step compares the last row, one sees the scan end, one forms start
// and finish and one writes back, registering the result word.
// Clear and unknown operations give no result.
// Clear sweeps the task table one entry a cycle.
// Output channel (out_valid_o / out_ready_i): one word per placed task, held
// in an output register. The next word is accepted while a result waits; a
// place stalls only in its write-back cycle until the output register frees.
// Reset: num_processors returns to 1 and the task table and processor rows are
// swept, with in_ready_o low. The APB port stays usable.
// APB: one register, num_processors at byte address 0; pready is always high.
`include "list_task_scheduler_macros.svh"

module list_task_scheduler #(
  parameter int unsigned MAX_PROCESSORS = lts_pkg::MaxProcessors,
  parameter int unsigned MAX_TASKS      = lts_pkg::MaxTasks
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lts_pkg::ApbAddrW-1:0]  paddr,
  input  logic [lts_pkg::ApbDataW-1:0]  pwdata,
  output logic [lts_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lts_pkg::OpW-1:0]       operation_i,
  input  logic [lts_pkg::TaskIdW-1:0]   task_id_i,
  input  logic [lts_pkg::ExecW-1:0]     exec_time_i,
  input  logic [lts_pkg::TaskIdW-1:0]   dep_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lts_pkg::TaskIdW-1:0]   task_id_out_o,
  output logic [lts_pkg::TimeW-1:0]     start_time_o,
  output logic [lts_pkg::TimeW-1:0]     finish_time_o,
  output logic [lts_pkg::ProcOutW-1:0]  processor_o,
  output logic [lts_pkg::TimeW-1:0]     processor_load_o
);

  localparam int unsigned TaskAw = $clog2(MAX_TASKS);

  lts_pkg::state_e                 state_q, state_d;
  logic [lts_pkg::NumProcW-1:0]    num_proc_q;
  lts_pkg::time_t                  pending_q, pending_d;

  logic [lts_pkg::TaskIdW-1:0]     tid_q;
  logic [lts_pkg::ExecW-1:0]       exec_q;
  lts_pkg::time_t                  start_q, finish_q, delta_q;
  lts_pkg::time_t                  start_c, finish_c, delta_c;
  logic [lts_pkg::TimeW:0]         sum_c;

  logic                            out_valid_q;
  logic [lts_pkg::TaskIdW-1:0]     out_tid_q;
  lts_pkg::time_t                  out_start_q, out_finish_q, out_load_q;
  logic [lts_pkg::ProcOutW-1:0]    out_proc_q;

  logic                            accept;
  logic                            commit_fire;
  logic                            cfg_wr;
  logic [31:0]                     dep_ext, tid_ext;
  logic                            dep_in_range, tid_in_range;

  logic                            mem_clr_start;
  logic                            mem_busy;
  logic                            mem_rd_en;
  lts_pkg::task_ent_t              mem_rd_data;

  lts_pkg::proc_ctrl_t             pctrl;
  lts_pkg::proc_stat_t             pstat;

  // Configuration register
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lts_pkg::RegNumProcessors) ?
                  lts_pkg::ApbDataW'(num_proc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_proc_q <= lts_pkg::NumProcW'(1);
    end else if (cfg_wr && paddr[2] == lts_pkg::RegNumProcessors) begin
      num_proc_q <= pwdata[lts_pkg::NumProcW-1:0];
    end
  end

  // Task table and processor rows
  assign dep_ext      = 32'(dep_id_i);
  assign tid_ext      = 32'(tid_q);
  assign dep_in_range = dep_ext < MAX_TASKS;
  assign tid_in_range = tid_ext < MAX_TASKS;

  lts_task_mem #(
    .MAX_TASKS (MAX_TASKS)
  ) u_task_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_start_i (mem_clr_start),
    .clr_busy_o  (mem_busy),
    .rd_en_i     (mem_rd_en),
    .rd_addr_i   (dep_ext[TaskAw-1:0]),
    .rd_data_o   (mem_rd_data),
    .wr_en_i     (commit_fire & tid_in_range),
    .wr_addr_i   (tid_ext[TaskAw-1:0]),
    .wr_data_i   (finish_q)
  );

  lts_proc_bank #(
    .MAX_PROCESSORS (MAX_PROCESSORS)
  ) u_proc_bank (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .num_processors_i (num_proc_q),
    .ctrl_i           (pctrl),
    .stat_o           (pstat)
  );

  assign in_ready_o  = (state_q == lts_pkg::StIdle) & !mem_busy & !pstat.busy;
  assign accept      = in_valid_i & in_ready_o;
  assign commit_fire = (state_q == lts_pkg::StCommit) & (!out_valid_q | out_ready_i);

  // Start is the later of free time and ready time; finish saturates
  always_comb begin
    start_c  = (pending_q > pstat.best_free) ? pending_q : pstat.best_free;
    sum_c    = {1'b0, start_c} + (lts_pkg::TimeW + 1)'(exec_q);
    finish_c = sum_c[lts_pkg::TimeW] ? '1 : sum_c[lts_pkg::TimeW-1:0];
    delta_c  = sum_c[lts_pkg::TimeW] ? ~start_c : lts_pkg::TimeW'(exec_q);
  end

  // Sequencer: next state and controls
  always_comb begin
    state_d             = state_q;
    pending_d           = pending_q;
    mem_rd_en           = 1'b0;
    mem_clr_start       = 1'b0;
    pctrl.clear         = 1'b0;
    pctrl.scan_start    = 1'b0;
    pctrl.commit        = commit_fire;
    pctrl.commit_free   = finish_q;
    pctrl.commit_delta  = delta_q;
    case (state_q)
      lts_pkg::StIdle: begin
        if (accept) begin
          case (operation_i)
            lts_pkg::OpAddDep: begin
              if (dep_in_range) begin
                mem_rd_en = 1'b1;
                state_d   = lts_pkg::StDep;
              end
            end
            lts_pkg::OpPlace: begin
              pctrl.scan_start = 1'b1;
              state_d          = lts_pkg::StScan;
            end
            lts_pkg::OpClear: begin
              pctrl.clear   = 1'b1;
              mem_clr_start = 1'b1;
              pending_d     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      lts_pkg::StDep: begin
        if (mem_rd_data.valid && mem_rd_data.finish > pending_q) begin
          pending_d = mem_rd_data.finish;
        end
        state_d = lts_pkg::StIdle;
      end
      lts_pkg::StScan: begin
        if (pstat.scan_done) begin
          state_d = lts_pkg::StPlace;
        end
      end
      lts_pkg::StPlace: begin
        state_d = lts_pkg::StCommit;
      end
      lts_pkg::StCommit: begin
        if (commit_fire) begin
          pending_d = '0;
          state_d   = lts_pkg::StIdle;
        end
      end
      default: begin
        state_d = lts_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lts_pkg::StIdle;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pending_q <= pending_d;
      if (commit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the word, the placement and the output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tid_q  <= task_id_i;
      exec_q <= exec_time_i;
    end
    if (state_q == lts_pkg::StPlace) begin
      start_q  <= start_c;
      finish_q <= finish_c;
      delta_q  <= delta_c;
    end
    if (commit_fire) begin
      out_tid_q    <= tid_q;
      out_start_q  <= start_q;
      out_finish_q <= finish_q;
      out_proc_q   <= pstat.proc_idx;
      out_load_q   <= pstat.load_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign task_id_out_o    = out_tid_q;
  assign start_time_o     = out_start_q;
  assign finish_time_o    = out_finish_q;
  assign processor_o      = out_proc_q;
  assign processor_load_o = out_load_q;

  `LTS_ASSERT_NEXT(a_place_starts_scan, accept && operation_i == lts_pkg::OpPlace,
                   state_q == lts_pkg::StScan, "place word did not start a scan")
  `LTS_ASSERT_NEXT(a_clear_sweeps, accept && operation_i == lts_pkg::OpClear,
                   mem_busy && pstat.busy && pending_q == '0, "clear did not start sweep")
  `LTS_ASSERT_NOW(a_finish_after_start, state_q == lts_pkg::StCommit,
                  finish_q >= start_q, "finish time before start time")
  `LTS_ASSERT_NEXT(a_commit_shows_word, commit_fire,
                   out_valid_o && state_q == lts_pkg::StIdle, "committed word not shown")

endmodule

// ===== rtl/lts_task_mem.sv =====
`include "list_task_scheduler_macros.svh"

module lts_task_mem #(
  parameter int unsigned MAX_TASKS = lts_pkg::MaxTasks,
  localparam int unsigned TaskAw = $clog2(MAX_TASKS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_start_i,
  output logic                clr_busy_o,
  input  logic                rd_en_i,
  input  logic [TaskAw-1:0]   rd_addr_i,
  output lts_pkg::task_ent_t  rd_data_o,
  input  logic                wr_en_i,
  input  logic [TaskAw-1:0]   wr_addr_i,
  input  lts_pkg::time_t      wr_data_i
);

  lts_pkg::task_ent_t ent_mem [MAX_TASKS];
  lts_pkg::task_ent_t rd_data_q;
  logic               clr_busy_q;
  logic [TaskAw-1:0]  clr_addr_q;

  // Sweep the table once after reset and after every clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_start_i) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == TaskAw'(MAX_TASKS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      ent_mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      ent_mem[wr_addr_i] <= {1'b1, wr_data_i};
    end
    if (rd_en_i) begin
      rd_data_q <= ent_mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

  `LTS_ASSERT_NOW(a_no_read_in_sweep, rd_en_i, !clr_busy_q, "task table read during sweep")
  `LTS_ASSERT_NOW(a_no_write_in_sweep, wr_en_i, !clr_busy_q, "task table write during sweep")

endmodule

// ===== rtl/lts_proc_bank.sv =====
`include "list_task_scheduler_macros.svh"

module lts_proc_bank #(
  parameter int unsigned MAX_PROCESSORS = lts_pkg::MaxProcessors
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lts_pkg::NumProcW-1:0]  num_processors_i,
  input  lts_pkg::proc_ctrl_t           ctrl_i,
  output lts_pkg::proc_stat_t           stat_o
);

  localparam int unsigned NumGroups = (MAX_PROCESSORS + lts_pkg::ScanLanes - 1) /
                                      lts_pkg::ScanLanes;
  localparam int unsigned GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
  localparam int unsigned CntW      = $clog2(MAX_PROCESSORS + 1);
  localparam int unsigned LaneW     = lts_pkg::LaneW;
  localparam int unsigned Lanes     = lts_pkg::ScanLanes;

  // Rows of free time and busy load, one processor per lane
  lts_pkg::time_t free_mem [NumGroups][Lanes];
  lts_pkg::time_t load_mem [NumGroups][Lanes];
  lts_pkg::time_t row_free_q [Lanes];
  lts_pkg::time_t row_load_q [Lanes];

  logic             clr_busy_q;
  logic [GrpW-1:0]  clr_row_q;

  logic             iss_act_q, iss_act_d;
  logic [GrpW-1:0]  iss_grp_q, iss_grp_d;
  logic             cmp_v_q, cmp_v_d;
  logic [GrpW-1:0]  cmp_grp_q, cmp_grp_d;
  logic             cmp_last_q, cmp_last_d;
  logic             done_q, done_d;

  logic             best_valid_q, best_valid_d;
  lts_pkg::time_t   best_free_q, best_free_d;
  lts_pkg::time_t   best_load_q, best_load_d;
  logic [GrpW-1:0]  best_grp_q, best_grp_d;
  logic [LaneW-1:0] best_lane_q, best_lane_d;

  logic [CntW-1:0]  count;
  logic             issue;
  logic [GrpW-1:0]  issue_grp;
  logic             issue_last;
  logic             lane_ok [Lanes];

  logic             b1, b3, b23;
  logic             w01_ok, w23_ok, g_ok;
  lts_pkg::time_t   w01_t, w23_t, g_t, w01_ld, w23_ld, g_ld;
  logic [LaneW-1:0] w01_l, w23_l, g_l;
  logic             take;
  logic [31:0]      idx_ext;

  // Clamp the processor count into 1..MAX_PROCESSORS
  always_comb begin
    if (num_processors_i == '0) begin
      count = CntW'(1);
    end else if (32'(num_processors_i) > MAX_PROCESSORS) begin
      count = CntW'(MAX_PROCESSORS);
    end else begin
      count = CntW'(num_processors_i);
    end
  end

  // Issue one row read per cycle until the last row in use
  assign issue      = ctrl_i.scan_start | iss_act_q;
  assign issue_grp  = ctrl_i.scan_start ? '0 : iss_grp_q;
  assign issue_last = (32'(issue_grp) * Lanes + Lanes) >= 32'(count);

  always_comb begin
    iss_act_d  = iss_act_q;
    iss_grp_d  = iss_grp_q;
    cmp_v_d    = 1'b0;
    cmp_grp_d  = cmp_grp_q;
    cmp_last_d = 1'b0;
    if (issue) begin
      iss_act_d  = !issue_last;
      iss_grp_d  = issue_grp + 1'b1;
      cmp_v_d    = 1'b1;
      cmp_grp_d  = issue_grp;
      cmp_last_d = issue_last;
    end
  end

  // Pick the earliest free lane of the row, lower lane on ties
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      lane_ok[l] = (32'(cmp_grp_q) * Lanes + 32'(l)) < 32'(count);
    end
    b1     = lane_ok[1] && (!lane_ok[0] || row_free_q[1] < row_free_q[0]);
    w01_ok = lane_ok[0] | lane_ok[1];
    w01_t  = b1 ? row_free_q[1] : row_free_q[0];
    w01_ld = b1 ? row_load_q[1] : row_load_q[0];
    w01_l  = b1 ? LaneW'(1) : LaneW'(0);
    b3     = lane_ok[3] && (!lane_ok[2] || row_free_q[3] < row_free_q[2]);
    w23_ok = lane_ok[2] | lane_ok[3];
    w23_t  = b3 ? row_free_q[3] : row_free_q[2];
    w23_ld = b3 ? row_load_q[3] : row_load_q[2];
    w23_l  = b3 ? LaneW'(3) : LaneW'(2);
    b23    = w23_ok && (!w01_ok || w23_t < w01_t);
    g_ok   = w01_ok | w23_ok;
    g_t    = b23 ? w23_t : w01_t;
    g_ld   = b23 ? w23_ld : w01_ld;
    g_l    = b23 ? w23_l : w01_l;
    take   = cmp_v_q && g_ok && (!best_valid_q || g_t < best_free_q);
  end

  // Merge the row winner into the running best
  always_comb begin
    best_valid_d = best_valid_q;
    best_free_d  = best_free_q;
    best_load_d  = best_load_q;
    best_grp_d   = best_grp_q;
    best_lane_d  = best_lane_q;
    done_d       = done_q;
    if (ctrl_i.scan_start) begin
      best_valid_d = 1'b0;
      done_d       = 1'b0;
    end else begin
      if (take) begin
        best_valid_d = 1'b1;
        best_free_d  = g_t;
        best_load_d  = g_ld;
        best_grp_d   = cmp_grp_q;
        best_lane_d  = g_l;
      end
      if (cmp_v_q && cmp_last_q) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q    <= 1'b0;
      iss_grp_q    <= '0;
      cmp_v_q      <= 1'b0;
      cmp_grp_q    <= '0;
      cmp_last_q   <= 1'b0;
      done_q       <= 1'b0;
      best_valid_q <= 1'b0;
      best_grp_q   <= '0;
      best_lane_q  <= '0;
    end else begin
      iss_act_q    <= iss_act_d;
      iss_grp_q    <= iss_grp_d;
      cmp_v_q      <= cmp_v_d;
      cmp_grp_q    <= cmp_grp_d;
      cmp_last_q   <= cmp_last_d;
      done_q       <= done_d;
      best_valid_q <= best_valid_d;
      best_grp_q   <= best_grp_d;
      best_lane_q  <= best_lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_free_q <= best_free_d;
    best_load_q <= best_load_d;
  end

  // Sweep rows to zero after reset and on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (ctrl_i.clear) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_row_q == GrpW'(NumGroups - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_row_q <= clr_row_q + 1'b1;
    end
  end

  // Row memory: write back the chosen lane, read one row a cycle
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      if (clr_busy_q) begin
        free_mem[clr_row_q][l] <= '0;
        load_mem[clr_row_q][l] <= '0;
      end else if (ctrl_i.commit && best_lane_q == LaneW'(l)) begin
        free_mem[best_grp_q][l] <= ctrl_i.commit_free;
        load_mem[best_grp_q][l] <= stat_o.load_new;
      end
    end
    if (issue) begin
      row_free_q <= free_mem[issue_grp];
      row_load_q <= load_mem[issue_grp];
    end
  end

  assign idx_ext = 32'(best_grp_q) * Lanes + 32'(best_lane_q);

  always_comb begin
    stat_o.busy      = clr_busy_q;
    stat_o.scan_done = done_q;
    stat_o.best_free = best_free_q;
    stat_o.load_new  = lts_pkg::sat_add(best_load_q, ctrl_i.commit_delta);
    stat_o.proc_idx  = idx_ext[lts_pkg::ProcOutW-1:0];
  end

  `LTS_ASSERT_NEXT(a_scan_finds_best, cmp_v_q && cmp_last_q && !ctrl_i.scan_start,
                   done_q && best_valid_q, "scan ended without a chosen processor")
  `LTS_ASSERT_NOW(a_commit_after_scan, ctrl_i.commit, done_q && best_valid_q,
                  "commit without a finished scan")

endmodule

// ===== bench/tb_list_task_scheduler.sv =====
`timescale 1ns / 100ps

module tb_list_task_scheduler;
  import lts_pkg::*;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned IdlePct      = 27;
  // Clear sweeps the task table one entry a cycle
  localparam int unsigned SettleCycles = MaxTasks + 64;
  localparam int unsigned RandomWords  = 1950;
  localparam longint unsigned TimeoutNs = 60_000_000;

  localparam logic [OpW-1:0]      OpUnknown   = 2'd3;
  localparam logic [ApbAddrW-1:0] NumProcAddr = {RegNumProcessors, 2'b00};

  typedef struct {
    logic [TaskIdW-1:0]  task_id;
    time_t               start;
    time_t               finish;
    logic [ProcOutW-1:0] proc;
    time_t               load;
  } placement_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata, prdata;
  logic                pready;
  logic                in_valid_i, in_ready_o;
  logic [OpW-1:0]      operation_i;
  logic [TaskIdW-1:0]  task_id_i, dep_id_i;
  logic [ExecW-1:0]    exec_time_i;
  logic                out_valid_o, out_ready_i;
  logic [TaskIdW-1:0]  task_id_out_o;
  logic [TimeW-1:0]    start_time_o, finish_time_o, processor_load_o;
  logic [ProcOutW-1:0] processor_o;

  // Schedule state mirrored by the predictor
  time_t               free_at [MaxProcessors];
  time_t               busy_sum[MaxProcessors];
  time_t               finish_tab[MaxTasks];
  bit                  finish_ok [MaxTasks];
  time_t               pend_ready;
  logic [NumProcW-1:0] num_proc;

  placement_t          placements_q[$];
  logic [TaskIdW-1:0]  placed_ids[$];
  int                  mismatches  = 0;
  int                  gap_pct     = IdlePct;
  int                  stall_pct   = IdlePct;
  int                  hold_cycles = 0;

  list_task_scheduler dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .task_id_i        (task_id_i),
    .exec_time_i      (exec_time_i),
    .dep_id_i         (dep_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .task_id_out_o    (task_id_out_o),
    .start_time_o     (start_time_o),
    .finish_time_o    (finish_time_o),
    .processor_o      (processor_o),
    .processor_load_o (processor_load_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Saturating 32-bit sum
  function automatic time_t clamp_sum(time_t a, time_t b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

  function automatic void clear_schedule();
    for (int i = 0; i < MaxProcessors; i++) begin
      free_at[i]  = '0;
      busy_sum[i] = '0;
    end
    for (int i = 0; i < MaxTasks; i++) finish_ok[i] = 1'b0;
    pend_ready = '0;
    placed_ids.delete();
  endfunction

  // Advance the schedule by one accepted word; queue the placement it yields
  function automatic void schedule_word(logic [OpW-1:0] op, logic [TaskIdW-1:0] tid,
                                        logic [ExecW-1:0] exec, logic [TaskIdW-1:0] dep);
    int unsigned cnt;
    int unsigned sel;
    time_t       start;
    time_t       finish;
    placement_t  p;
    case (op)
      OpAddDep: begin
        if (finish_ok[dep] && finish_tab[dep] > pend_ready) pend_ready = finish_tab[dep];
      end
      OpClear: clear_schedule();
      OpPlace: begin
        cnt = (num_proc == 0) ? 1 : (num_proc > MaxProcessors) ? MaxProcessors : num_proc;
        sel = 0;
        for (int i = 1; i < cnt; i++) if (free_at[i] < free_at[sel]) sel = i;
        start  = (pend_ready > free_at[sel]) ? pend_ready : free_at[sel];
        finish = clamp_sum(start, time_t'(exec));
        free_at[sel]    = finish;
        busy_sum[sel]   = clamp_sum(busy_sum[sel], finish - start);
        finish_tab[tid] = finish;
        finish_ok[tid]  = 1'b1;
        pend_ready      = '0;
        placed_ids.insert(placed_ids.size(), tid);
        if (placed_ids.size() > 64) void'(placed_ids.pop_front());
        p.task_id = tid;
        p.start   = start;
        p.finish  = finish;
        p.proc    = sel[ProcOutW-1:0];
        p.load    = busy_sum[sel];
        placements_q.insert(placements_q.size(), p);
      end
      default: ;
    endcase
  endfunction

  // Offer one word, with a random gap before it, and hold it until accepted
  task automatic send_word(logic [OpW-1:0] op, logic [TaskIdW-1:0] tid,
                           logic [ExecW-1:0] exec, logic [TaskIdW-1:0] dep);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    task_id_i   <= tid;
    exec_time_i <= exec;
    dep_id_i    <= dep;
    do @(posedge clk_i); while (!in_ready_o);
    schedule_word(op, tid, exec, dep);
  endtask

  // Drop valid and wait until every placement has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (placements_q.size() != 0);
  endtask

  // Let a clear or dependency word still in flight finish as well
  task automatic settle();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_num_processors(logic [NumProcW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NumProcAddr;
    pwdata  <= {{(ApbDataW - NumProcW){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    num_proc = value;
  endtask

  // Mostly recently placed tasks, sometimes any id
  function automatic logic [TaskIdW-1:0] pick_dep();
    if (placed_ids.size() != 0 && $urandom_range(99) < 80)
      return placed_ids[$urandom_range(placed_ids.size() - 1)];
    return TaskIdW'($urandom);
  endfunction

  function automatic logic [ExecW-1:0] pick_exec();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return ExecW'($urandom_range(1, 40));
      default: return ExecW'($urandom);
    endcase
  endfunction

  task automatic test_single_processor();
    send_word(OpPlace, 8'd0, 16'h0000, 8'hFF);
    send_word(OpPlace, 8'hFF, 16'hFFFF, 8'h00);
  endtask

  // Scheduled, unscheduled and no-later dependencies, then a repeated id
  task automatic test_dependency_chain();
    send_word(OpAddDep, 8'd0, 16'd0, 8'hFF);
    send_word(OpAddDep, 8'd0, 16'd0, 8'd7);
    send_word(OpAddDep, 8'hFF, 16'hFFFF, 8'd0);
    send_word(OpPlace, 8'd10, 16'd3, 8'd0);
    send_word(OpPlace, 8'hFF, 16'd1, 8'd0);
    send_word(OpAddDep, 8'd0, 16'd0, 8'hFF);
    send_word(OpPlace, 8'd11, 16'd2, 8'd0);
  endtask

  task automatic test_clear_and_unknown();
    send_word(OpUnknown, 8'hFF, 16'hFFFF, 8'hFF);
    send_word(OpClear, 8'd0, 16'd0, 8'd0);
    send_word(OpAddDep, 8'd0, 16'd0, 8'hFF);
    send_word(OpPlace, 8'd1, 16'd9, 8'd0);
  endtask

  // Out-of-range counts clamp to the processor array, zero means one
  task automatic test_processor_count();
    settle();
    write_num_processors(4'hF);
    for (int i = 0; i < 9; i++)
      send_word(OpPlace, 8'(20 + i), (i < 4) ? 16'd4 : 16'(i), 8'd0);
    settle();
    write_num_processors(4'h0);
    send_word(OpPlace, 8'd40, 16'd5, 8'd0);
    send_word(OpPlace, 8'd41, 16'd5, 8'd0);
  endtask

  // Stall the output long enough to fill the block, then pause the sender
  task automatic test_backpressure();
    settle();
    write_num_processors(4'd4);
    gap_pct     = 0;
    hold_cycles = 300;
    for (int i = 0; i < 12; i++)
      send_word(OpPlace, 8'(100 + i), 16'($urandom_range(1, 20)), 8'($urandom));
    drain_results();
    gap_pct = IdlePct;
    for (int i = 0; i < 6; i++)
      send_word(OpPlace, 8'(120 + i), 16'($urandom_range(1, 20)), 8'($urandom));
  endtask

  task automatic test_random_mix();
    logic [NumProcW-1:0] counts[6];
    int                  per_phase;
    int                  n;
    int                  roll;
    counts    = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, NumProcW'($urandom_range(2, 7))};
    per_phase = RandomWords / 6;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_num_processors(counts[ph]);
      // One phase runs with no idling on either side
      gap_pct   = (ph == 2) ? 0 : IdlePct;
      stall_pct = (ph == 2) ? 0 : IdlePct;
      n = 0;
      while (n < per_phase) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_word(OpUnknown, TaskIdW'($urandom), ExecW'($urandom), TaskIdW'($urandom));
        end else begin
          if (roll < 5)
            send_word(OpClear, TaskIdW'($urandom), ExecW'($urandom), TaskIdW'($urandom));
          else if (roll < 50)
            send_word(OpAddDep, TaskIdW'($urandom), ExecW'($urandom), pick_dep());
          else
            send_word(OpPlace, TaskIdW'($urandom), pick_exec(), TaskIdW'($urandom));
          n++;
        end
      end
    end
    gap_pct   = IdlePct;
    stall_pct = IdlePct;
  endtask

  // Result side: random stalls, or a long hold when asked
  initial begin
    int n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest placement
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (placements_q.size() == 0) begin
        $error("result word for task %0d with no placement pending", task_id_out_o);
        mismatches++;
      end else begin
        want = placements_q.pop_front();
        if (task_id_out_o !== want.task_id) begin
          $error("task_id_out: expected %0d, got %0d", want.task_id, task_id_out_o);
          mismatches++;
        end
        if (start_time_o !== want.start) begin
          $error("start_time: expected %0d, got %0d", want.start, start_time_o);
          mismatches++;
        end
        if (finish_time_o !== want.finish) begin
          $error("finish_time: expected %0d, got %0d", want.finish, finish_time_o);
          mismatches++;
        end
        if (processor_o !== want.proc) begin
          $error("processor: expected %0d, got %0d", want.proc, processor_o);
          mismatches++;
        end
        if (processor_load_o !== want.load) begin
          $error("processor_load: expected %0d, got %0d", want.load, processor_load_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("list_task_scheduler verification failed");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    operation_i <= OpAddDep;
    task_id_i   <= '0;
    exec_time_i <= '0;
    dep_id_i    <= '0;
    clear_schedule();
    num_proc = 4'd1;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_single_processor();
    test_dependency_chain();
    test_clear_and_unknown();
    test_processor_count();
    test_backpressure();
    test_random_mix();

    // Wait out the last results and any trailing clear
    settle();
    if (mismatches == 0) begin
      $display("list_task_scheduler verification clean");
    end else begin
      $display("list_task_scheduler verification failed");
    end
    $finish;
  end

endmodule
